// File: hdl/rdh_pkg.sv
package rdh_pkg;

  localparam int COUNT_W   = 8;
  localparam int GROUP_W   = 5;
  localparam int SLOT_W    = 3;
  localparam int BIN_SLOTS = 4;

  typedef logic [COUNT_W-1:0] count_t;

  localparam count_t COUNT_MAX = count_t'(255);

  typedef struct packed {
    logic               take;
    logic               emit;
    logic               last_group;
    logic [SLOT_W-1:0]  slot;
    logic [GROUP_W-1:0] group;
  } sweep_ctl_t;

endpackage

// File: hdl/rdh_ram.sv
module rdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/rdh_accum.sv
module rdh_accum #(
  parameter int BINS = 128
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,
  input  logic [7:0]              disparity,
  input  rdh_pkg::count_t         rdata,
  output logic [$clog2(BINS)-1:0] rd_addr,
  output logic                    wr_en,
  output logic [$clog2(BINS)-1:0] wr_addr,
  output rdh_pkg::count_t         wr_data
);
  import rdh_pkg::*;

  localparam int AW = $clog2(BINS);

  logic          s1_valid;
  logic [AW-1:0] s1_addr;
  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  count_t        fwd_data;
  count_t        cur;

  assign rd_addr = ({1'b0, disparity} >= 9'(BINS)) ? AW'(BINS - 1) : AW'(disparity);

  // hold the previous write for a back-to-back read-after-write hit
  assign cur     = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : rdata;
  assign wr_en   = s1_valid;
  assign wr_addr = s1_addr;
  assign wr_data = (cur == COUNT_MAX) ? cur : cur + count_t'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s1_valid  <= take;
      fwd_valid <= s1_valid;
    end
    s1_addr  <= rd_addr;
    fwd_addr <= s1_addr;
    fwd_data <= wr_data;
  end

endmodule

// File: hdl/rdh_group.sv
module rdh_group (
  input  logic                          clk,
  input  logic                          rst,
  input  rdh_pkg::sweep_ctl_t           ctl,
  input  rdh_pkg::count_t               rdata,
  output logic                          out_free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rdh_pkg::GROUP_W-1:0]   group_index,
  output rdh_pkg::count_t               bin0_count,
  output rdh_pkg::count_t               bin1_count,
  output rdh_pkg::count_t               bin2_count,
  output rdh_pkg::count_t               bin3_count,
  output logic                          last_group
);
  import rdh_pkg::*;

  count_t grp [BIN_SLOTS];
  count_t merged [BIN_SLOTS];

  assign out_free = !out_valid || out_ready;

  always_comb begin
    for (int k = 0; k < BIN_SLOTS; k++) begin
      merged[k] = (32'(ctl.slot) == k) ? rdata : grp[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int k = 0; k < BIN_SLOTS; k++) begin
        grp[k] <= '0;
      end
    end else begin
      if (ctl.take && ctl.emit) begin
        out_valid <= 1'b1;
        for (int k = 0; k < BIN_SLOTS; k++) begin
          grp[k] <= '0;
        end
      end else begin
        if (out_ready) begin
          out_valid <= 1'b0;
        end
        if (ctl.take) begin
          for (int k = 0; k < BIN_SLOTS; k++) begin
            grp[k] <= merged[k];
          end
        end
      end
    end
    if (ctl.take && ctl.emit) begin
      group_index <= ctl.group;
      bin0_count  <= merged[0];
      bin1_count  <= merged[1];
      bin2_count  <= merged[2];
      bin3_count  <= merged[3];
      last_group  <= ctl.last_group;
    end
  end

endmodule

// File: hdl/row_disparity_histogram_unit.sv
// channel  direction  transaction                        handshake
// input    in         disparity, row_end                 in_valid / in_ready
// output   out        group_index, bins 0-3, last_group  out_valid / out_ready
//
// One pixel per cycle while in_ready is high; the bin store does a two-stage
// read-modify-write with forwarding of the previous cycle's write.
// After a row-end pixel the input stalls through the drain and the readout,
// plus any waits of the output register on out_ready; the readout visits each
// bin in a read and a write-back state through the single memory read port
// and zeroes it behind. After reset the store is zeroed before any pixel.
module row_disparity_histogram_unit #(
  parameter int BINS            = 128,
  parameter int BINS_PER_RESULT = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  disparity,
  input  logic                        row_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rdh_pkg::GROUP_W-1:0] group_index,
  output rdh_pkg::count_t             bin0_count,
  output rdh_pkg::count_t             bin1_count,
  output rdh_pkg::count_t             bin2_count,
  output rdh_pkg::count_t             bin3_count,
  output logic                        last_group
);
  import rdh_pkg::*;

  localparam int AW     = $clog2(BINS);
  localparam int GROUPS = (BINS + BINS_PER_RESULT - 1) / BINS_PER_RESULT;
  localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int JW     = (BINS_PER_RESULT > 1) ? $clog2(BINS_PER_RESULT) : 1;

  typedef enum logic [2:0] {
    CLEAR,
    ACCUM,
    DRAIN,
    SWEEP_RD,
    SWEEP_WB
  } state_t;

  state_t        state;
  logic [AW-1:0] addr;
  logic [JW-1:0] slot;
  logic [GW-1:0] group;

  logic          take;
  logic [AW-1:0] acc_rd_addr;
  logic          acc_wr_en;
  logic [AW-1:0] acc_wr_addr;
  count_t        acc_wr_data;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  count_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  count_t        ram_rdata;

  logic          out_free;
  logic          at_last_bin;
  logic          group_done;
  logic          go;
  sweep_ctl_t    ctl;

  assign in_ready    = (state == ACCUM);
  assign take        = in_valid && in_ready;
  assign at_last_bin = (addr == AW'(BINS - 1));
  assign group_done  = at_last_bin || (32'(slot) == BINS_PER_RESULT - 1);
  assign go          = (state == SWEEP_WB) && (!group_done || out_free);

  assign ctl.take       = go;
  assign ctl.emit       = group_done;
  assign ctl.last_group = at_last_bin;
  assign ctl.slot       = SLOT_W'(slot);
  assign ctl.group      = GROUP_W'(group);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = '0;
    ram_raddr = addr;
    case (state)
      CLEAR: begin
        ram_we = 1'b1;
      end
      ACCUM, DRAIN: begin
        ram_we    = acc_wr_en;
        ram_waddr = acc_wr_addr;
        ram_wdata = acc_wr_data;
        ram_raddr = acc_rd_addr;
      end
      SWEEP_WB: begin
        ram_we = go;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
      addr  <= '0;
      slot  <= '0;
      group <= '0;
    end else begin
      case (state)
        CLEAR: begin
          addr <= addr + AW'(1);
          if (at_last_bin) begin
            addr  <= '0;
            state <= ACCUM;
          end
        end
        ACCUM: begin
          if (take && row_end) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          addr  <= '0;
          slot  <= '0;
          group <= '0;
          state <= SWEEP_RD;
        end
        SWEEP_RD: begin
          state <= SWEEP_WB;
        end
        SWEEP_WB: begin
          if (go) begin
            addr <= addr + AW'(1);
            if (group_done) begin
              slot  <= '0;
              group <= group + GW'(1);
            end else begin
              slot <= slot + JW'(1);
            end
            if (at_last_bin) begin
              addr  <= '0;
              state <= ACCUM;
            end else begin
              state <= SWEEP_RD;
            end
          end
        end
        default: begin
          state <= CLEAR;
        end
      endcase
    end
  end

  rdh_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(BINS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  rdh_accum #(
    .BINS(BINS)
  ) u_accum (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .disparity(disparity),
    .rdata    (ram_rdata),
    .rd_addr  (acc_rd_addr),
    .wr_en    (acc_wr_en),
    .wr_addr  (acc_wr_addr),
    .wr_data  (acc_wr_data)
  );

  rdh_group u_group (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .rdata      (ram_rdata),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .group_index(group_index),
    .bin0_count (bin0_count),
    .bin1_count (bin1_count),
    .bin2_count (bin2_count),
    .bin3_count (bin3_count),
    .last_group (last_group)
  );

endmodule
